### rtl/core/png_ru_pkg.sv
// Shared types, register indexes and the Paeth predictor for the PNG row unfilter.
// No dependencies; imported by every module under rtl/core.
package png_ru_pkg;

   typedef enum logic [2:0] {
      FILT_NONE  = 3'd0,
      FILT_SUB   = 3'd1,
      FILT_UP    = 3'd2,
      FILT_AVG   = 3'd3,
      FILT_PAETH = 3'd4
   } filter_type;

   localparam logic [1:0] CSR_ROW_BYTES    = 2'd0;
   localparam logic [1:0] CSR_PIXEL_STRIDE = 2'd1;
   localparam logic [1:0] CSR_IMAGE_ROWS   = 2'd2;

   localparam int ROW_BYTES_W = 14;
   localparam int STRIDE_W    = 4;
   localparam int ROWS_W      = 16;
   localparam int CSR_DATA_W  = 16;

   typedef struct packed {
      logic       valid;
      logic [7:0] data;
      filter_type filter;
      logic       first_row;
      logic       use_left;
      logic       row_end;
      logic       image_end;
   } stage_type;

   function automatic logic [7:0] paeth_predict(input logic [7:0] a, input logic [7:0] b,
                                                input logic [7:0] c);
      logic signed [10:0] sa, sb, sc, da, db, dc;
      logic [10:0]        pa, pb, pc;
      logic [7:0]         res;
      sa = signed'({3'b000, a});
      sb = signed'({3'b000, b});
      sc = signed'({3'b000, c});
      da = sb - sc;
      db = sa - sc;
      dc = sa + sb - (sc <<< 1);
      pa = (da < 0) ? 11'(-da) : 11'(da);
      pb = (db < 0) ? 11'(-db) : 11'(db);
      pc = (dc < 0) ? 11'(-dc) : 11'(dc);
      if (pa <= pb && pa <= pc) begin
         res = a;
      end else if (pb <= pc) begin
         res = b;
      end else begin
         res = c;
      end
      return res;
   endfunction

endpackage

### rtl/core/png_ru_row_mem.sv
// Previous-row byte store: one write port, one registered read port.
// Write-to-read forwarding on a same-address collision. Uses png_ru_pkg.
module png_ru_row_mem
   import png_ru_pkg::*;
#(
   parameter int DEPTH = 8192,
   parameter int AW    = 13
) (
   input  logic          clock,
   input  logic          rd_en,
   input  logic [AW-1:0] rd_addr,
   output logic [7:0]    rd_data,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [7:0]    wr_data
);

   logic [7:0] mem [DEPTH];
   logic [7:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         if (wr_en && wr_addr == rd_addr) begin
            rd_data_ff <= wr_data;
         end else begin
            rd_data_ff <= mem[rd_addr];
         end
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/core/png_ru_seq.sv
// Row and image sequencing: filter capture, byte position, row count, prior-row read.
// Loads the reconstruction stage register. Uses png_ru_pkg.
module png_ru_seq
   import png_ru_pkg::*;
#(
   parameter int MAX_ROW_BYTES = 8192,
   parameter int AW            = 13
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [7:0]             req_stream_byte,
   input  logic [ROW_BYTES_W-1:0] row_bytes,
   input  logic [STRIDE_W-1:0]    stride,
   input  logic [ROWS_W-1:0]      image_rows,
   input  logic                   stage_take,
   output stage_type              stage,
   output logic [AW-1:0]          stage_addr,
   output logic                   mem_rd_en,
   output logic [AW-1:0]          mem_rd_addr
);

   localparam int PW = $clog2(MAX_ROW_BYTES + 1);
   localparam int LW = (PW > ROW_BYTES_W) ? PW : ROW_BYTES_W;

   logic [PW-1:0]     pos_ff, pos_in;
   filter_type        filter_ff, filter_in;
   logic [ROWS_W-1:0] rows_done_ff, rows_done_in;
   logic              first_row_ff, first_row_in;
   stage_type         stage_ff, stage_in;
   logic [AW-1:0]     addr_ff, addr_in;

   logic              accept, take_data, row_end, image_end;
   logic [LW-1:0]     len, pos_x, idx;
   logic [ROWS_W:0]   rows_lim, rows_next;

   always_comb begin
      if (row_bytes == '0) begin
         len = LW'(1);
      end else if (LW'(row_bytes) > LW'(MAX_ROW_BYTES)) begin
         len = LW'(MAX_ROW_BYTES);
      end else begin
         len = LW'(row_bytes);
      end
      rows_lim  = (image_rows == '0) ? (ROWS_W+1)'(1) : {1'b0, image_rows};
      rows_next = {1'b0, rows_done_ff} + (ROWS_W+1)'(1);
      pos_x     = LW'(pos_ff);
      idx       = pos_x - LW'(1);
      if (idx >= len) begin
         idx = len - LW'(1);
      end
      row_end   = pos_x >= len;
      image_end = row_end && (rows_next >= rows_lim);
   end

   assign req_ready = !stage_ff.valid || stage_take;
   assign accept    = req_valid && req_ready;
   assign take_data = accept && (pos_ff != '0);

   always_comb begin
      pos_in       = pos_ff;
      filter_in    = filter_ff;
      rows_done_in = rows_done_ff;
      first_row_in = first_row_ff;
      addr_in      = addr_ff;
      stage_in     = stage_ff;
      if (stage_take) begin
         stage_in.valid = 1'b0;
      end
      if (accept && pos_ff == '0) begin
         filter_in = (req_stream_byte <= 8'(FILT_PAETH)) ? filter_type'(req_stream_byte[2:0])
                                                         : FILT_NONE;
         pos_in    = PW'(1);
      end
      if (take_data) begin
         addr_in            = idx[AW-1:0];
         stage_in.valid     = 1'b1;
         stage_in.data      = req_stream_byte;
         stage_in.filter    = filter_ff;
         stage_in.first_row = first_row_ff;
         stage_in.use_left  = idx >= LW'(stride);
         stage_in.row_end   = row_end;
         stage_in.image_end = image_end;
         if (row_end) begin
            pos_in = '0;
            if (image_end) begin
               rows_done_in = '0;
               first_row_in = 1'b1;
            end else begin
               rows_done_in = rows_next[ROWS_W-1:0];
               first_row_in = 1'b0;
            end
         end else begin
            pos_in = pos_ff + PW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff       <= '0;
         filter_ff    <= FILT_NONE;
         rows_done_ff <= '0;
         first_row_ff <= 1'b1;
         stage_ff     <= '0;
      end else begin
         pos_ff       <= pos_in;
         filter_ff    <= filter_in;
         rows_done_ff <= rows_done_in;
         first_row_ff <= first_row_in;
         stage_ff     <= stage_in;
      end
   end

   always_ff @(posedge clock) begin
      addr_ff <= addr_in;
   end

   assign stage       = stage_ff;
   assign stage_addr  = addr_ff;
   assign mem_rd_en   = take_data;
   assign mem_rd_addr = idx[AW-1:0];

   property p_load_needs_room;
      @(posedge clock) disable iff (reset)
         take_data |-> (!stage_ff.valid || stage_take);
   endproperty
   a_load_needs_room: assert property (p_load_needs_room)
      else $error("stage register overwritten while held");

   property p_image_end_restarts;
      @(posedge clock) disable iff (reset)
         (take_data && image_end) |=> (first_row_ff && rows_done_ff == '0 && pos_ff == '0);
   endproperty
   a_image_end_restarts: assert property (p_image_end_restarts)
      else $error("image end did not restart row history");

endmodule

### rtl/core/png_ru_recon.sv
// Byte reconstruction: left and upper-left pixel history, predictors, output register.
// Writes each reconstructed byte back to the row store. Uses png_ru_pkg.
module png_ru_recon
   import png_ru_pkg::*;
#(
   parameter int MAX_PIXEL_BYTES = 8
) (
   input  logic                clock,
   input  logic                reset,
   input  stage_type           stage,
   input  logic [7:0]          prior_byte,
   input  logic [STRIDE_W-1:0] stride,
   output logic                stage_take,
   output logic                mem_wr_en,
   output logic [7:0]          mem_wr_data,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [7:0]          rsp_recon_byte,
   output logic                rsp_row_end,
   output logic                rsp_image_end
);

   localparam int LIW = (MAX_PIXEL_BYTES > 1) ? $clog2(MAX_PIXEL_BYTES) : 1;

   logic [7:0]          left_ff  [MAX_PIXEL_BYTES];
   logic [7:0]          upper_ff [MAX_PIXEL_BYTES];
   logic                rsp_valid_ff, rsp_valid_in;
   logic [7:0]          recon_ff;
   logic                row_end_ff, image_end_ff;
   logic [STRIDE_W-1:0] stride_m1;
   logic [LIW-1:0]      sel;
   logic [7:0]          a, b, c, pred, recon;
   logic [8:0]          sum_ab;

   always_comb begin
      stride_m1 = stride - STRIDE_W'(1);
      sel       = stride_m1[LIW-1:0];
      a         = stage.use_left ? left_ff[sel] : 8'd0;
      b         = stage.first_row ? 8'd0 : prior_byte;
      c         = (stage.use_left && !stage.first_row) ? upper_ff[sel] : 8'd0;
      sum_ab    = {1'b0, a} + {1'b0, b};
      case (stage.filter)
         FILT_SUB:   pred = a;
         FILT_UP:    pred = b;
         FILT_AVG:   pred = sum_ab[8:1];
         FILT_PAETH: pred = paeth_predict(a, b, c);
         default:    pred = 8'd0;
      endcase
      recon = stage.data + pred;
   end

   assign stage_take   = stage.valid && (!rsp_valid_ff || rsp_ready);
   assign rsp_valid_in = stage_take || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (stage_take) begin
         recon_ff     <= recon;
         row_end_ff   <= stage.row_end;
         image_end_ff <= stage.image_end;
         left_ff[0]   <= recon;
         upper_ff[0]  <= b;
         for (int k = 1; k < MAX_PIXEL_BYTES; k++) begin
            left_ff[k]  <= left_ff[k-1];
            upper_ff[k] <= upper_ff[k-1];
         end
      end
   end

   assign mem_wr_en      = stage_take;
   assign mem_wr_data    = recon;
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_recon_byte = recon_ff;
   assign rsp_row_end    = row_end_ff;
   assign rsp_image_end  = image_end_ff;

endmodule

### rtl/core/png_row_unfilter_core.sv
// PNG row unfilter top level: configuration registers and the three core units.
// Depends on png_ru_pkg, png_ru_seq, png_ru_recon and png_ru_row_mem.
//
// Usage:
//   req_ channel carries the decompressed stream, one byte per transfer. The
//   first byte of each row is the filter code and yields no result; every
//   following byte yields one rsp_ transfer with the reconstructed byte,
//   rsp_row_end on the last byte of a row and rsp_image_end on the last byte
//   of the last row of an image.
//   csr_ port writes row_bytes, pixel_stride and image_rows; write only while
//   the block is idle.
//   A data byte accepted on req_ passes the stage register and then the
//   output register before it is offered on rsp_. Throughput: one byte per
//   cycle while rsp_ready is high, set by the single read-modify-write of the
//   row store per byte (read at accept, write as it leaves the stage register).
//   Reset clears sequencing state and waits for a filter byte on the first row
//   of an image; no clearing pass of the row store is needed.
//   When rsp_ready is low one result is held and one more byte is taken into
//   the stage register; req_ready then drops until the result is taken.
module png_row_unfilter_core
   import png_ru_pkg::*;
#(
   parameter int MAX_ROW_BYTES   = 8192,
   parameter int MAX_PIXEL_BYTES = 8
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [7:0]            req_stream_byte,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [7:0]            rsp_recon_byte,
   output logic                  rsp_row_end,
   output logic                  rsp_image_end,
   input  logic                  csr_wr_en,
   input  logic [1:0]            csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int AW = (MAX_ROW_BYTES > 1) ? $clog2(MAX_ROW_BYTES) : 1;

   logic [ROW_BYTES_W-1:0] row_bytes_ff;
   logic [STRIDE_W-1:0]    stride_ff, stride;
   logic [ROWS_W-1:0]      image_rows_ff;

   stage_type     stage;
   logic [AW-1:0] stage_addr, rd_addr;
   logic          stage_take, rd_en, wr_en;
   logic [7:0]    rd_data, wr_data;

   always_ff @(posedge clock) begin
      if (reset) begin
         row_bytes_ff  <= ROW_BYTES_W'(1);
         stride_ff     <= STRIDE_W'(1);
         image_rows_ff <= ROWS_W'(1);
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_ROW_BYTES:    row_bytes_ff  <= csr_wdata[ROW_BYTES_W-1:0];
            CSR_PIXEL_STRIDE: stride_ff     <= csr_wdata[STRIDE_W-1:0];
            CSR_IMAGE_ROWS:   image_rows_ff <= csr_wdata[ROWS_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      if (stride_ff == '0) begin
         stride = STRIDE_W'(1);
      end else if (stride_ff > STRIDE_W'(MAX_PIXEL_BYTES)) begin
         stride = STRIDE_W'(MAX_PIXEL_BYTES);
      end else begin
         stride = stride_ff;
      end
   end

   png_ru_seq #(
      .MAX_ROW_BYTES (MAX_ROW_BYTES),
      .AW            (AW)
   ) u_seq (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_stream_byte (req_stream_byte),
      .row_bytes       (row_bytes_ff),
      .stride          (stride),
      .image_rows      (image_rows_ff),
      .stage_take      (stage_take),
      .stage           (stage),
      .stage_addr      (stage_addr),
      .mem_rd_en       (rd_en),
      .mem_rd_addr     (rd_addr)
   );

   png_ru_row_mem #(
      .DEPTH (MAX_ROW_BYTES),
      .AW    (AW)
   ) u_row_mem (
      .clock   (clock),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data),
      .wr_en   (wr_en),
      .wr_addr (stage_addr),
      .wr_data (wr_data)
   );

   png_ru_recon #(
      .MAX_PIXEL_BYTES (MAX_PIXEL_BYTES)
   ) u_recon (
      .clock          (clock),
      .reset          (reset),
      .stage          (stage),
      .prior_byte     (rd_data),
      .stride         (stride),
      .stage_take     (stage_take),
      .mem_wr_en      (wr_en),
      .mem_wr_data    (wr_data),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_recon_byte (rsp_recon_byte),
      .rsp_row_end    (rsp_row_end),
      .rsp_image_end  (rsp_image_end)
   );

   property p_image_end_is_row_end;
      @(posedge clock) disable iff (reset)
         (rsp_valid && rsp_image_end) |-> rsp_row_end;
   endproperty
   a_image_end_is_row_end: assert property (p_image_end_is_row_end)
      else $error("image end without row end");

   property p_result_from_stage;
      @(posedge clock) disable iff (reset)
         $rose(rsp_valid) |-> $past(stage.valid);
   endproperty
   a_result_from_stage: assert property (p_result_from_stage)
      else $error("result appeared with no byte in the stage register");

   property p_stall_only_when_full;
      @(posedge clock) disable iff (reset)
         !req_ready |-> (stage.valid && rsp_valid && !rsp_ready);
   endproperty
   a_stall_only_when_full: assert property (p_stall_only_when_full)
      else $error("input stalled while room was available");

endmodule

### verif/tb_png_row_unfilter_core.sv
// Testbench for png_row_unfilter_core: random and directed PNG row streams are checked
// byte by byte against an in-bench unfilter predictor. Depends on png_ru_pkg and the
// core RTL only.
`timescale 1ns / 1ps

module tb_png_row_unfilter_core;
   import png_ru_pkg::*;

   localparam int ROW_STORE_DEPTH = 8192;
   localparam int HIST_DEPTH      = 8;
   localparam int CYCLE_LIMIT     = 1_000_000;
   localparam int RANDOM_ITEMS    = 800;
   localparam int SETTLE_CYCLES   = 4;
   localparam int LONG_ROW_BYTES  = 200;

   localparam logic [7:0] CODE_UNKNOWN_MIN = 8'(FILT_PAETH) + 8'd1;
   localparam logic [7:0] CODE_UNKNOWN_MAX = 8'hFF;

   typedef enum int {FILL_RANDOM, FILL_ZERO, FILL_ONES, FILL_ALT} fill_kind_type;

   typedef struct packed {
      logic [7:0] recon;
      logic       row_end;
      logic       image_end;
   } recon_item_type;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  req_valid;
   logic                  req_ready;
   logic [7:0]            req_stream_byte;
   logic                  rsp_valid;
   logic                  rsp_ready;
   logic [7:0]            rsp_recon_byte;
   logic                  rsp_row_end;
   logic                  rsp_image_end;
   logic                  csr_wr_en;
   logic [1:0]            csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   png_row_unfilter_core dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_stream_byte (req_stream_byte),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_recon_byte  (rsp_recon_byte),
      .rsp_row_end     (rsp_row_end),
      .rsp_image_end   (rsp_image_end),
      .csr_wr_en       (csr_wr_en),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // unfilter state mirrored in the bench
   logic [ROW_STORE_DEPTH-1:0][7:0] row_store;
   logic [7:0]                      left_hist  [HIST_DEPTH];
   logic [7:0]                      upper_hist [HIST_DEPTH];
   filter_type                      active_filt;
   int                              byte_pos;
   logic [15:0]                     rows_done;
   logic                            first_row;
   int                              stored_len;
   logic [ROW_BYTES_W-1:0]          cfg_row_bytes;
   logic [STRIDE_W-1:0]             cfg_stride;
   logic [ROWS_W-1:0]               cfg_image_rows;

   recon_item_type expected_bytes[$];
   recon_item_type head;
   int             fail_count  = 0;
   int             cycle_count = 0;
   int             burst_left  = 0;
   int             ready_mode  = 0;

   function automatic logic [7:0] paeth_pick(input logic [7:0] a, input logic [7:0] b,
                                             input logic [7:0] c);
      int pa, pb, pc;
      pa = int'(b) - int'(c);
      pb = int'(a) - int'(c);
      pc = int'(a) + int'(b) - 2 * int'(c);
      if (pa < 0) pa = -pa;
      if (pb < 0) pb = -pb;
      if (pc < 0) pc = -pc;
      if (pa <= pb && pa <= pc) return a;
      if (pb <= pc) return b;
      return c;
   endfunction

   task automatic unfilter_byte(input logic [7:0] x);
      int             len, stride, rows, idx;
      logic [7:0]     a, b, c, guess, recon;
      logic [8:0]     sum;
      recon_item_type item;
      if (byte_pos == 0) begin
         if (x <= 8'(FILT_PAETH)) active_filt = filter_type'(x[2:0]);
         else active_filt = FILT_NONE;
         left_hist  = '{default: '0};
         upper_hist = '{default: '0};
         byte_pos = 1;
         return;
      end
      len = int'(cfg_row_bytes);
      if (len == 0) len = 1;
      if (len > ROW_STORE_DEPTH) len = ROW_STORE_DEPTH;
      stride = int'(cfg_stride);
      if (stride == 0) stride = 1;
      if (stride > HIST_DEPTH) stride = HIST_DEPTH;
      rows = int'(cfg_image_rows);
      if (rows == 0) rows = 1;
      idx = byte_pos - 1;
      if (idx >= len) idx = len - 1;
      a = (idx >= stride) ? left_hist[stride-1] : 8'h00;
      b = first_row ? 8'h00 : row_store[idx];
      c = (idx >= stride && !first_row) ? upper_hist[stride-1] : 8'h00;
      sum = {1'b0, a} + {1'b0, b};
      case (active_filt)
         FILT_SUB:   guess = a;
         FILT_UP:    guess = b;
         FILT_AVG:   guess = sum[8:1];
         FILT_PAETH: guess = paeth_pick(a, b, c);
         default:    guess = 8'h00;
      endcase
      recon = x + guess;
      row_store[idx] = recon;
      if (idx + 1 > stored_len) stored_len = idx + 1;
      for (int k = HIST_DEPTH - 1; k > 0; k--) begin
         left_hist[k]  = left_hist[k-1];
         upper_hist[k] = upper_hist[k-1];
      end
      left_hist[0]  = recon;
      upper_hist[0] = b;
      item.recon     = recon;
      item.row_end   = (byte_pos >= len);
      item.image_end = 1'b0;
      if (item.row_end) begin
         byte_pos = 0;
         if (int'(rows_done) + 1 >= rows) begin
            item.image_end = 1'b1;
            rows_done = '0;
            first_row = 1'b1;
         end else begin
            rows_done = rows_done + 16'd1;
            first_row = 1'b0;
         end
      end else begin
         byte_pos++;
      end
      expected_bytes.push_back(item);
   endtask

   task automatic send_byte(input logic [7:0] value);
      req_valid       <= 1'b1;
      req_stream_byte <= value;
      do @(posedge clock); while (!req_ready);
      unfilter_byte(value);
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
         burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 400)
                                                  : $urandom_range(0, 24);
      end
   endtask

   task automatic send_row(input logic [7:0] code, input int len, input fill_kind_type fill);
      logic [7:0] value;
      send_byte(code);
      for (int k = 0; k < len; k++) begin
         case (fill)
            FILL_ZERO: value = 8'h00;
            FILL_ONES: value = 8'hFF;
            FILL_ALT:  value = k[0] ? 8'hFF : 8'h00;
            default: begin
               case ($urandom_range(0, 9))
                  0:       value = 8'h00;
                  1:       value = 8'hFF;
                  default: value = 8'($urandom);
               endcase
            end
         endcase
         send_byte(value);
      end
   endtask

   // drain results, then hold off for the block's own pipeline
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (expected_bytes.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_config(input logic [15:0] row_bytes, input logic [15:0] stride,
                             input logic [15:0] image_rows);
      csr_wr_en <= 1'b1;
      csr_index <= CSR_ROW_BYTES;
      csr_wdata <= row_bytes;
      @(posedge clock);
      cfg_row_bytes = row_bytes[ROW_BYTES_W-1:0];
      csr_index <= CSR_PIXEL_STRIDE;
      csr_wdata <= stride;
      @(posedge clock);
      cfg_stride = stride[STRIDE_W-1:0];
      csr_index <= CSR_IMAGE_ROWS;
      csr_wdata <= image_rows;
      @(posedge clock);
      cfg_image_rows = image_rows[ROWS_W-1:0];
      csr_wr_en <= 1'b0;
   endtask

   task automatic test_reset_defaults();
      send_row(FILT_PAETH, 1, FILL_ONES);
      send_row(CODE_UNKNOWN_MIN, 1, FILL_RANDOM);
      wait_idle();
   endtask

   task automatic test_filter_types();
      set_config(16'd3, 16'd1, 16'd5);
      send_row(FILT_SUB, 3, FILL_ALT);
      send_row(FILT_UP, 3, FILL_ONES);
      send_row(FILT_AVG, 3, FILL_RANDOM);
      send_row(FILT_PAETH, 3, FILL_RANDOM);
      send_row(FILT_NONE, 3, FILL_ZERO);
      wait_idle();
   endtask

   task automatic test_special_cases();
      // zero length, stride and height act as one
      set_config(16'd0, 16'd0, 16'd0);
      send_row(FILT_SUB, 1, FILL_ONES);
      send_row(CODE_UNKNOWN_MAX, 1, FILL_RANDOM);
      wait_idle();
      set_config(16'd9, 16'd15, 16'd1);
      send_row(FILT_SUB, 9, FILL_ALT);
      wait_idle();
      // shrink the row under a partly received row
      set_config(16'd6, 16'd1, 16'd1);
      send_byte(FILT_SUB);
      repeat (4) send_byte(8'($urandom));
      wait_idle();
      set_config(16'd2, 16'd1, 16'd1);
      send_byte(8'($urandom));
      wait_idle();
   endtask

   // saturated row length and stride, then end the row by shrinking the length
   task automatic test_full_width_rows();
      set_config(16'hFFFF, 16'hFFFF, 16'd2);
      send_byte(FILT_PAETH);
      repeat (LONG_ROW_BYTES) send_byte(8'($urandom));
      wait_idle();
      set_config(16'(LONG_ROW_BYTES), 16'hFFFF, 16'd2);
      send_byte(8'($urandom));
      send_row(FILT_PAETH, LONG_ROW_BYTES, FILL_RANDOM);
      wait_idle();
   endtask

   task automatic test_random_images();
      int         sent, rb, st, ir, eff_len, n_rows;
      logic [7:0] code;
      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         case ($urandom_range(0, 19))
            0:         rb = 0;
            1, 2:      rb = $urandom_range(41, 200);
            3, 4, 5:   rb = $urandom_range(13, 40);
            default:   rb = $urandom_range(1, 12);
         endcase
         eff_len = (rb == 0) ? 1 : rb;
         // keep reads of the row store inside what has been written
         if (!first_row && eff_len > stored_len) begin
            rb = stored_len;
            eff_len = stored_len;
         end
         case ($urandom_range(0, 19))
            0:       st = 0;
            1:       st = $urandom_range(9, 15);
            default: st = $urandom_range(1, HIST_DEPTH);
         endcase
         case ($urandom_range(0, 19))
            0:       ir = 0;
            1:       ir = 16'hFFFF;
            2:       ir = $urandom_range(6, 16'hFFFE);
            default: ir = $urandom_range(1, 5);
         endcase
         set_config(16'(rb), 16'(st), 16'(ir));
         n_rows = 1 + $urandom_range(0, 150 / (eff_len + 1));
         repeat (n_rows) begin
            if ($urandom_range(0, 6) == 0) begin
               code = 8'($urandom_range(int'(CODE_UNKNOWN_MIN), int'(CODE_UNKNOWN_MAX)));
            end else begin
               code = 8'($urandom_range(int'(FILT_NONE), int'(FILT_PAETH)));
            end
            send_row(code, eff_len, FILL_RANDOM);
            sent += eff_len + 1;
         end
         wait_idle();
      end
   endtask

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("tb_png_row_unfilter_core: FAIL");
         $finish;
      end
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_bytes.size() == 0) begin
               $error("transfer with nothing expected: recon_byte %02h", rsp_recon_byte);
               fail_count++;
            end else begin
               head = expected_bytes.pop_front();
               if (rsp_recon_byte !== head.recon) begin
                  $error("recon_byte expected %02h actual %02h", head.recon, rsp_recon_byte);
                  fail_count++;
               end
               if (rsp_row_end !== head.row_end) begin
                  $error("row_end expected %0b actual %0b", head.row_end, rsp_row_end);
                  fail_count++;
               end
               if (rsp_image_end !== head.image_end) begin
                  $error("image_end expected %0b actual %0b", head.image_end, rsp_image_end);
                  fail_count++;
               end
            end
         end
         if (cycle_count % 256 == 0) ready_mode = $urandom_range(0, 3);
         case (ready_mode)
            0:       rsp_ready <= 1'b1;
            1:       rsp_ready <= 1'($urandom_range(0, 1));
            2:       rsp_ready <= ($urandom_range(0, 3) == 0);
            default: rsp_ready <= (cycle_count % 7 < 4);
         endcase
      end
   end

   initial begin
      reset           = 1'b1;
      req_valid       = 1'b0;
      req_stream_byte = 8'h00;
      csr_wr_en       = 1'b0;
      csr_index       = CSR_ROW_BYTES;
      csr_wdata       = '0;
      row_store       = '0;
      left_hist       = '{default: '0};
      upper_hist      = '{default: '0};
      active_filt     = FILT_NONE;
      byte_pos        = 0;
      rows_done       = '0;
      first_row       = 1'b1;
      stored_len      = 0;
      cfg_row_bytes   = ROW_BYTES_W'(1);
      cfg_stride      = STRIDE_W'(1);
      cfg_image_rows  = ROWS_W'(1);
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_defaults();
      test_filter_types();
      test_special_cases();
      test_full_width_rows();
      test_random_images();

      while (expected_bytes.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (fail_count == 0) begin
         $display("tb_png_row_unfilter_core: PASS");
      end else begin
         $display("tb_png_row_unfilter_core: FAIL");
      end
      $finish;
   end

endmodule

### png_row_unfilter_core.f
rtl/core/png_ru_pkg.sv
rtl/core/png_ru_row_mem.sv
rtl/core/png_ru_seq.sv
rtl/core/png_ru_recon.sv
rtl/core/png_row_unfilter_core.sv
verif/tb_png_row_unfilter_core.sv
